// ----- design/ihs_pkg.sv -----
// Shared types and constants for the hop search block.
package ihs_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;
    localparam logic [6:0] NODE_COUNT_RST  = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_WR,
        S_SCAN,
        S_DRAIN,
        S_LEVEL
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_rows;
        logic add_rd;
        logic add_wr;
        logic q_init;
        logic scan_rd;
        logic level_upd;
        logic finish;
        logic fin_found;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       edge_ok;
        logic       src_eq_goal;
        logic       src_ok;
        logic       single_node;
        logic       last_idx;
        logic       hit;
        logic       next_empty;
        logic       depth_last;
    } t_dp_stat;

endpackage

// ----- design/iterative_deepening_hop_search.sv -----
// Clear acts in the decode state; add edge reads its row there and writes it back merged in
// the add-write state. A query with source equal to goal or no search finishes in decode; a
// searching query runs L levels (at most the clamped node_count-1), each reading every matrix
// row once from the single memory port, then a drain and an update state. One word at a time;
// start is taken only while busy is low. Synchronous reset empties the graph at once through
// row valid bits, sets node_count to 64 and returns the sequencer to idle.
module iterative_deepening_hop_search #(
    parameter int MAX_NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_edge_from,
    input  logic [5:0]  i_edge_to,
    input  logic [5:0]  i_source,
    input  logic [5:0]  i_goal,
    output logic        o_valid,
    output logic        o_found,
    output logic [5:0]  o_hops,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]        r_node_count;
    ihs_pkg::t_dp_cmd  dp_cmd;
    ihs_pkg::t_dp_stat dp_stat;
    logic              ctrl_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ihs_pkg::NODE_COUNT_RST;
        end else if (psel && penable && pwrite && (paddr == ihs_pkg::ADDR_NODE_COUNT)) begin
            r_node_count <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ihs_pkg::ADDR_NODE_COUNT) ? {25'd0, r_node_count} : 32'd0;

    ihs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (ctrl_busy)
    );

    ihs_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_node_count (r_node_count),
        .i_cmd_code   (i_cmd),
        .i_edge_from  (i_edge_from),
        .i_edge_to    (i_edge_to),
        .i_source     (i_source),
        .i_goal       (i_goal),
        .o_stat       (dp_stat),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_hops       (o_hops)
    );

    assign busy = ctrl_busy;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without prior work");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_miss_zero_hops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_hops == 6'd0))
        else $error("miss reported with nonzero hops");

endmodule

// ----- design/ihs_ctrl.sv -----
// Sequencer for clear, edge add and level-by-level query.
module ihs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ihs_pkg::t_dp_stat  i_stat,
    output ihs_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    ihs_pkg::t_state r_state;
    ihs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ihs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ihs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ihs_pkg::S_DECODE;
                end
            end
            ihs_pkg::S_DECODE: begin
                n_state = ihs_pkg::S_IDLE;
                case (i_stat.cmd)
                    ihs_pkg::CMD_CLEAR: begin
                        o_cmd.clear_rows = 1'b1;
                    end
                    ihs_pkg::CMD_ADD: begin
                        // read the row here, merge and write it back next cycle
                        if (i_stat.edge_ok) begin
                            o_cmd.add_rd = 1'b1;
                            n_state      = ihs_pkg::S_ADD_WR;
                        end
                    end
                    ihs_pkg::CMD_QUERY: begin
                        if (i_stat.src_eq_goal) begin
                            o_cmd.finish    = 1'b1;
                            o_cmd.fin_found = 1'b1;
                        end else if (!i_stat.src_ok || i_stat.single_node) begin
                            o_cmd.finish = 1'b1;
                        end else begin
                            o_cmd.q_init = 1'b1;
                            n_state      = ihs_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        n_state = ihs_pkg::S_IDLE;
                    end
                endcase
            end
            ihs_pkg::S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = ihs_pkg::S_IDLE;
            end
            ihs_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.last_idx) begin
                    n_state = ihs_pkg::S_DRAIN;
                end
            end
            ihs_pkg::S_DRAIN: begin
                n_state = ihs_pkg::S_LEVEL;
            end
            ihs_pkg::S_LEVEL: begin
                o_cmd.level_upd = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.fin_found = 1'b1;
                    n_state         = ihs_pkg::S_IDLE;
                end else if (i_stat.next_empty || i_stat.depth_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ihs_pkg::S_IDLE;
                end else begin
                    n_state = ihs_pkg::S_SCAN;
                end
            end
            default: begin
                n_state = ihs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ihs_pkg::S_IDLE);

endmodule

// ----- design/ihs_dp.sv -----
// Edge matrix memory, search sets and result registers.
module ihs_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ihs_pkg::t_dp_cmd   i_cmd,
    input  logic [6:0]         i_node_count,
    input  logic [1:0]         i_cmd_code,
    input  logic [5:0]         i_edge_from,
    input  logic [5:0]         i_edge_to,
    input  logic [5:0]         i_source,
    input  logic [5:0]         i_goal,
    output ihs_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    output logic               o_found,
    output logic [5:0]         o_hops
);

    localparam int NW = $clog2(MAX_NODES);
    localparam logic [MAX_NODES-1:0] ONE = {{(MAX_NODES-1){1'b0}}, 1'b1};
    localparam logic [6:0] MAX_N7 = 7'(MAX_NODES);

    logic [1:0]           r_cmd_code;
    logic [5:0]           r_edge_from;
    logic [5:0]           r_edge_to;
    logic [5:0]           r_src;
    logic [5:0]           r_goal;

    logic [MAX_NODES-1:0] r_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_vld;
    logic [MAX_NODES-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_sel;

    logic [MAX_NODES-1:0] r_reached;
    logic [MAX_NODES-1:0] r_frontier;
    logic [MAX_NODES-1:0] r_acc;
    logic [NW-1:0]        r_idx;
    logic [6:0]           r_depth;

    logic                 r_out_vld;
    logic                 r_found;
    logic [5:0]           r_hops;

    logic [6:0]           n_used;
    logic [MAX_NODES-1:0] node_mask;
    logic [MAX_NODES-1:0] next_set;
    logic [NW-1:0]        ef_idx;
    logic [NW-1:0]        rd_addr;
    logic [MAX_NODES-1:0] add_row;
    logic                 goal_ok;

    // clamp node count to 1..MAX_NODES
    always_comb begin
        if (i_node_count == 7'd0) begin
            n_used = 7'd1;
        end else if (i_node_count > MAX_N7) begin
            n_used = MAX_N7;
        end else begin
            n_used = i_node_count;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            node_mask[j] = (7'(j) < n_used);
        end
    end

    assign next_set = r_acc & node_mask & ~r_reached;
    assign ef_idx   = r_edge_from[NW-1:0];
    assign rd_addr  = i_cmd.add_rd ? ef_idx : r_idx;
    assign add_row  = (r_row_vld[ef_idx] ? r_rd_data : '0) | (ONE << r_edge_to[NW-1:0]);
    assign goal_ok  = ({1'b0, r_goal} < MAX_N7);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_code  <= i_cmd_code;
            r_edge_from <= i_edge_from;
            r_edge_to   <= i_edge_to;
            r_src       <= i_source;
            r_goal      <= i_goal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_mem[ef_idx] <= add_row;
        end
        if (i_cmd.add_rd || i_cmd.scan_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // a row whose valid bit is low reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clear_rows) begin
            r_row_vld <= '0;
        end else if (i_cmd.add_wr) begin
            r_row_vld[ef_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_sel <= r_frontier[r_idx] & r_row_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_reached  <= ONE << r_src[NW-1:0];
            r_frontier <= ONE << r_src[NW-1:0];
            r_idx      <= '0;
            r_depth    <= 7'd1;
        end else if (i_cmd.level_upd) begin
            r_reached  <= r_reached | next_set;
            r_frontier <= next_set;
            r_idx      <= '0;
            r_depth    <= r_depth + 7'd1;
        end else if (i_cmd.scan_rd) begin
            r_idx <= r_idx + NW'(1);
        end
    end

    // fold the frontier rows into the next level
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init || i_cmd.level_upd) begin
            r_acc <= '0;
        end else if (r_rd_vld && r_rd_sel) begin
            r_acc <= r_acc | r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found <= i_cmd.fin_found;
            r_hops  <= (i_cmd.fin_found && (r_src != r_goal)) ? r_depth[5:0] : 6'd0;
        end
    end

    assign o_stat.cmd         = r_cmd_code;
    assign o_stat.edge_ok     = ({1'b0, r_edge_from} < MAX_N7) && ({1'b0, r_edge_to} < MAX_N7);
    assign o_stat.src_eq_goal = (r_src == r_goal);
    assign o_stat.src_ok      = ({1'b0, r_src} < MAX_N7);
    assign o_stat.single_node = (n_used == 7'd1);
    assign o_stat.last_idx    = (r_idx == NW'(MAX_NODES - 1));
    assign o_stat.hit         = goal_ok && next_set[r_goal[NW-1:0]];
    assign o_stat.next_empty  = (next_set == '0);
    assign o_stat.depth_last  = (({1'b0, r_depth} + 8'd1) >= {1'b0, n_used});

    assign o_valid = r_out_vld;
    assign o_found = r_found;
    assign o_hops  = r_hops;

endmodule

// ----- bench/iterative_deepening_hop_search_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the hop search block: graph edits and queries against a level search.
module iterative_deepening_hop_search_tb;

    typedef struct packed {
        logic       found;
        logic [5:0] hops;
    } t_hop_answer;

    // Mirror of the stored graph plus the answers still owed by the block.
    class hop_search_predictor;
        logic [63:0] adj_rows [64];
        logic [6:0]  node_count;
        t_hop_answer answers [$];
        int          errors;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            node_count = ihs_pkg::NODE_COUNT_RST;
            errors     = 0;
        endfunction

        function t_hop_answer shortest_hops(logic [5:0] src, logic [5:0] goal);
            int          n;
            logic [63:0] in_use;
            logic [63:0] seen;
            logic [63:0] wave;
            logic [63:0] nxt;
            t_hop_answer ans;
            n = (node_count == 0) ? 1 : (node_count > 64) ? 64 : int'(node_count);
            in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            ans = '0;
            if (src == goal) begin
                ans.found = 1'b1;
                return ans;
            end
            // A source outside the node range still expands its own row.
            seen = 64'd1 << src;
            wave = seen;
            for (int d = 1; d < n; d++) begin
                nxt = '0;
                for (int i = 0; i < 64; i++)
                    if (wave[i]) nxt |= adj_rows[i];
                nxt &= in_use & ~seen;
                seen |= nxt;
                wave = nxt;
                if (nxt[goal]) begin
                    ans.found = 1'b1;
                    ans.hops  = 6'(d);
                    return ans;
                end
                if (nxt == '0) break;
            end
            return ans;
        endfunction

        function void note_word(logic [1:0] cmd, logic [5:0] ef, logic [5:0] et,
                                logic [5:0] src, logic [5:0] goal);
            case (cmd)
                ihs_pkg::CMD_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
                ihs_pkg::CMD_ADD:   adj_rows[ef][et] = 1'b1;
                ihs_pkg::CMD_QUERY: answers.insert(answers.size(), shortest_hops(src, goal));
                default: ;
            endcase
        endfunction

        function void check_answer(logic found, logic [5:0] hops);
            t_hop_answer want;
            if (answers.size() == 0) begin
                $error("unexpected answer word: found=%0b hops=%0d", found, hops);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, found);
                errors++;
            end
            if (hops !== want.hops) begin
                $error("hops: expected %0d, got %0d", want.hops, hops);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd       = '0;
    logic [5:0]  i_edge_from = '0;
    logic [5:0]  i_edge_to   = '0;
    logic [5:0]  i_source    = '0;
    logic [5:0]  i_goal      = '0;
    logic        o_valid;
    logic        o_found;
    logic [5:0]  o_hops;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [1:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    hop_search_predictor hop_model;
    int                  sender_idle_pct;
    logic [6:0]          phase_node_count [9] = '{7'd8, 7'd1, 7'd64, 7'd0, 7'd100,
                                                   7'd5, 7'd127, 7'd16, 7'd64};

    iterative_deepening_hop_search dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) hop_model.check_answer(o_found, o_hops);
    end

    function automatic logic [5:0] rnd6();
        return 6'($urandom());
    endfunction

    // Present one word, hold until taken, then maybe drop start and idle.
    task automatic send_word(logic [1:0] cmd, logic [5:0] ef, logic [5:0] et,
                             logic [5:0] src, logic [5:0] goal);
        i_cmd       <= cmd;
        i_edge_from <= ef;
        i_edge_to   <= et;
        i_source    <= src;
        i_goal      <= goal;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        hop_model.note_word(cmd, ef, et, src, goal);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every answer is in and the block has gone quiet.
    task automatic drain_answers();
        start <= 1'b0;
        while (hop_model.answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic read_node_count(logic [6:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ihs_pkg::ADDR_NODE_COUNT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[6:0] !== want) begin
            $error("node_count readback: expected %0d, got %0d", want, prdata[6:0]);
            hop_model.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_node_count(logic [6:0] value);
        drain_answers();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ihs_pkg::ADDR_NODE_COUNT;
        pwdata  <= {25'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hop_model.node_count = value;
        @(posedge i_clk);
        read_node_count(value);
    endtask

    // Mostly edge walks followed by queries from the walk start, plus clears and noise.
    task automatic run_phase(logic [6:0] cfg, int quota);
        int         n;
        int         done;
        logic [1:0] cmd;
        logic [5:0] walk_start;
        logic [5:0] walk_end;
        logic [5:0] next_node;
        write_node_count(cfg);
        n = (cfg == 0) ? 1 : (cfg > 64) ? 64 : int'(cfg);
        done = 0;
        while (done < quota) begin
            case ($urandom_range(9))
                0: begin
                    send_word(ihs_pkg::CMD_CLEAR, rnd6(), rnd6(), rnd6(), rnd6());
                    done++;
                end
                1: begin
                    cmd = 2'($urandom());
                    send_word(cmd, rnd6(), rnd6(), rnd6(), rnd6());
                    if (cmd != ihs_pkg::CMD_UNUSED) done++;
                end
                default: begin
                    walk_start = 6'($urandom_range(n - 1));
                    walk_end   = walk_start;
                    repeat ($urandom_range(1, 6)) begin
                        next_node = 6'($urandom_range(n - 1));
                        send_word(ihs_pkg::CMD_ADD, walk_end, next_node, rnd6(), rnd6());
                        walk_end = next_node;
                        done++;
                    end
                    repeat ($urandom_range(1, 2)) begin
                        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), walk_start,
                                  $urandom_range(1) ? walk_end : 6'($urandom_range(n - 1)));
                        done++;
                    end
                end
            endcase
            if ($urandom_range(15) == 0) drain_answers();
        end
    endtask

    initial begin
        hop_model       = new();
        sender_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_node_count(ihs_pkg::NODE_COUNT_RST);

        // Source equal to goal, empty graph, node zero as goal, longer path.
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd0, 6'd0);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd63, 6'd63);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd5, 6'd9);
        send_word(ihs_pkg::CMD_ADD, 6'd63, 6'd0, rnd6(), rnd6());
        send_word(ihs_pkg::CMD_ADD, 6'd0, 6'd63, rnd6(), rnd6());
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd63, 6'd0);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd0, 6'd63);
        send_word(ihs_pkg::CMD_ADD, 6'd62, 6'd1, rnd6(), rnd6());
        send_word(ihs_pkg::CMD_ADD, 6'd1, 6'd0, rnd6(), rnd6());
        send_word(ihs_pkg::CMD_UNUSED, 6'h3f, 6'h3f, 6'h3f, 6'h3f);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd62, 6'd63);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd0, 6'd62);

        // Two nodes: sources above the range expand, heads above it are dropped.
        write_node_count(7'd2);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd62, 6'd1);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd63, 6'd0);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd62, 6'd0);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd0, 6'd63);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd40, 6'd40);
        send_word(ihs_pkg::CMD_CLEAR, 6'h3f, 6'h3f, 6'h3f, 6'h3f);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd63, 6'd0);

        for (int p = 0; p < 9; p++) begin
            sender_idle_pct = (p < 3) ? 17 : (p < 6) ? 80 : 0;
            run_phase(phase_node_count[p], 3);
        end

        // Full-length chain for the deepest search.
        send_word(ihs_pkg::CMD_CLEAR, rnd6(), rnd6(), rnd6(), rnd6());
        for (int i = 0; i < 63; i++)
            send_word(ihs_pkg::CMD_ADD, 6'(i), 6'(i + 1), rnd6(), rnd6());
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd0, 6'd63);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd63, 6'd0);
        send_word(ihs_pkg::CMD_QUERY, rnd6(), rnd6(), 6'd20, 6'd52);

        drain_answers();
        repeat (8) @(posedge i_clk);
        if (hop_model.errors == 0 && hop_model.answers.size() == 0) begin
            $display("iterative_deepening_hop_search_tb: clean");
        end else begin
            $display("iterative_deepening_hop_search_tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("iterative_deepening_hop_search_tb: errors");
        $finish;
    end

endmodule
